// ----- hdl/sma_pkg.sv -----
`timescale 1ns / 1ps

package sma_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MASTER_VOLUME = 1'd0;
	localparam cfg_idx_t REG_OUTPUT_FORMAT = 1'd1;

	localparam logic FMT_S16 = 1'b0;
	localparam logic FMT_U8  = 1'b1;

	localparam logic [7:0] MASTER_VOLUME_RST = 8'd255;

	typedef enum logic [1:0] {
		MODE_MIX   = 2'd0,
		MODE_RAW   = 2'd1,
		MODE_DRAIN = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_READ,
		ST_UPDATE
	} state_t;

	localparam logic signed [23:0] SAT_MAX = 24'sd32767;
	localparam logic signed [23:0] SAT_MIN = -24'sd32768;

	// accumulator fraction bits dropped on scaling and on drain
	localparam int FRAC_SHIFT = 8;

endpackage

// ----- hdl/sma_item_if.sv -----
`timescale 1ns / 1ps

interface sma_item_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  mode;
	logic        [11:0] position;
	logic signed [23:0] left_sample;
	logic signed [23:0] right_sample;
	logic        [7:0]  left_gain;
	logic        [7:0]  right_gain;

	modport source (
		output valid, mode, position, left_sample, right_sample, left_gain, right_gain,
		input  ready
	);
	modport sink (
		input  valid, mode, position, left_sample, right_sample, left_gain, right_gain,
		output ready
	);
endinterface

// ----- hdl/sma_result_if.sv -----
`timescale 1ns / 1ps

interface sma_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;

	modport source (
		output valid, left_out, right_out,
		input  ready
	);
	modport sink (
		input  valid, left_out, right_out,
		output ready
	);
endinterface

// ----- hdl/stereo_mix_accumulator.sv -----
`timescale 1ns / 1ps

// Stereo mix buffer: MIX_DEPTH pairs of 32-bit wrapping accumulators kept in one
// single-port-read RAM (left in the upper half of each word). Mix beats add a
// sample scaled by gain * master_volume >> 8, raw beats add the sample as is,
// drain beats return the pair >> 8 clamped to 16 bits (or offset 8-bit) and
// zero the entry. Each beat is a read-modify-write of the RAM (index and gain
// multiply, RAM read, write back), and no new beat is taken until it ends; a
// drain beat waits further while the previous result has not been taken. After
// reset the block sweeps all MIX_DEPTH RAM entries to zero, one per cycle, before
// it takes its first beat; configuration writes are taken throughout.
module stereo_mix_accumulator
	import sma_pkg::*;
#(
	parameter int MIX_DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sma_item_if.sink              item,
	sma_result_if.source          result
);

	localparam int AW = (MIX_DEPTH > 1) ? $clog2(MIX_DEPTH) : 1;
	// position mod MIX_DEPTH via reciprocal; exact for 12-bit positions when MIX_DEPTH >= 9, so that RECIP fits 21 bits
	localparam logic [20:0] RECIP   = 21'((2 ** 24 + MIX_DEPTH - 1) / MIX_DEPTH);
	localparam logic [16:0] DEPTH_C = 17'(MIX_DEPTH);

	state_t state_q, state_d;

	logic [7:0] master_volume_q;
	logic       output_format_q;

	logic [AW-1:0] clr_q;

	logic [1:0]         mode_q;
	logic [11:0]        pos_q;
	logic signed [23:0] ls_q, rs_q;
	logic [7:0]         lg_q, rg_q;

	logic [8:0]  quot_q;
	logic [15:0] lvol_q, rvol_q;

	logic [AW-1:0] idx_q;
	logic [31:0]   ladd_q, radd_q;

	logic               out_valid_q;
	logic signed [15:0] lout_q, rout_q;

	logic [32:0]         quot_prod;
	logic [25:0]         idx_full;
	logic [AW-1:0]       idx_d;
	logic signed [40:0]  lprod, rprod;
	logic [31:0]         ladd_d, radd_d;
	logic [63:0]         rd_data;
	logic [63:0]         wr_data;
	logic [AW-1:0]       wr_addr;
	logic                wr_en;
	logic                rd_en;
	logic                accept;
	logic                is_drain;
	logic                out_load;
	logic                upd_hold;

	function automatic logic [15:0] drain_fn(input logic [31:0] acc, input logic fmt);
		logic signed [23:0] s;
		logic signed [15:0] v;
		s = $signed(acc[31:FRAC_SHIFT]);
		if (s > SAT_MAX) begin
			v = 16'sh7fff;
		end else if (s < SAT_MIN) begin
			v = -16'sh8000;
		end else begin
			v = s[15:0];
		end
		if (fmt == FMT_U8) begin
			// floor(v / 256) + 128
			drain_fn = {8'd0, ~v[15], v[14:8]};
		end else begin
			drain_fn = v;
		end
	endfunction

	sma_ram #(
		.WIDTH(64),
		.DEPTH(MIX_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(idx_d),
		.rdata(rd_data)
	);

	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign is_drain   = (mode_q == MODE_DRAIN);
	assign upd_hold   = is_drain && out_valid_q && !result.ready;
	assign out_load   = (state_q == ST_UPDATE) && is_drain && !upd_hold;

	assign quot_prod = 33'(pos_q) * 33'(RECIP);
	assign idx_full  = 26'(pos_q) - 26'(quot_q) * 26'(DEPTH_C);
	assign idx_d     = idx_full[AW-1:0];

	assign lprod = ls_q * $signed({1'b0, lvol_q});
	assign rprod = rs_q * $signed({1'b0, rvol_q});

	always_comb begin
		ladd_d = 32'(ls_q);
		radd_d = 32'(rs_q);
		if (mode_q == MODE_MIX) begin
			ladd_d = lprod[39:FRAC_SHIFT];
			radd_d = rprod[39:FRAC_SHIFT];
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == AW'(MIX_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!upd_hold) begin
					state_d = ST_IDLE;
					case (mode_q)
						MODE_MIX, MODE_RAW: begin
							wr_en   = 1'b1;
							wr_data = {rd_data[63:32] + ladd_q, rd_data[31:0] + radd_q};
						end
						MODE_DRAIN: begin
							wr_en = 1'b1;
						end
						default: begin
							wr_en = 1'b0;
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_q           <= '0;
			master_volume_q <= MASTER_VOLUME_RST;
			output_format_q <= FMT_S16;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MASTER_VOLUME: master_volume_q <= cfg_data;
					REG_OUTPUT_FORMAT: output_format_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.mode;
			pos_q  <= item.position;
			ls_q   <= item.left_sample;
			rs_q   <= item.right_sample;
			lg_q   <= item.left_gain;
			rg_q   <= item.right_gain;
		end
		if (state_q == ST_MUL) begin
			quot_q <= quot_prod[32:24];
			lvol_q <= lg_q * master_volume_q;
			rvol_q <= rg_q * master_volume_q;
		end
		if (state_q == ST_READ) begin
			idx_q  <= idx_d;
			ladd_q <= ladd_d;
			radd_q <= radd_d;
		end
		if (out_load) begin
			lout_q <= drain_fn(rd_data[63:32], output_format_q);
			rout_q <= drain_fn(rd_data[31:0], output_format_q);
		end
	end

	assign result.valid     = out_valid_q;
	assign result.left_out  = lout_q;
	assign result.right_out = rout_q;

endmodule

// ----- hdl/sma_ram.sv -----
`timescale 1ns / 1ps

module sma_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/sma_checker.sv -----
`timescale 1ns / 1ps

module sma_checker
	import sma_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input cfg_idx_t              cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [15:0]           left_out,
	input logic [15:0]           right_out
);

	logic fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_S16;
		end else if (cfg_we && cfg_index == REG_OUTPUT_FORMAT) begin
			fmt_q <= cfg_data[0];
		end
	end

	// one beat in flight: no back-to-back accepts
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted in consecutive cycles");

	// 8-bit format leaves the upper byte clear
	a_u8_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fmt_q == FMT_U8 |-> left_out[15:8] == 8'd0 && right_out[15:8] == 8'd0)
		else $error("8-bit output out of range");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(left_out) && $stable(right_out))
		else $error("result payload changed while stalled");

endmodule

bind stereo_mix_accumulator sma_checker u_sma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_we   (cfg_we),
	.cfg_index(cfg_index),
	.cfg_data (cfg_data),
	.in_valid (item.valid),
	.in_ready (item.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.left_out (result.left_out),
	.right_out(result.right_out)
);
